FILE: hdl/swfp_pkg.sv
// Shared types and constants for the sliding-window frame pacer.
package swfp_pkg;

    localparam int STAMP_W    = 32;
    localparam int WAIT_W     = 11;
    localparam int RATE_W     = 20;
    localparam int DIV_W      = 33;
    localparam int STEP_W     = 6;
    localparam int DUE_W      = 20;
    localparam int FPS_SCALE  = 1000;
    localparam int RATE_SCALE = 200000;

    localparam logic [WAIT_W-1:0] WAIT_MAX   = 11'd2047;
    localparam logic [RATE_W-1:0] RATE_MAX   = 20'd999999;
    localparam logic [RATE_W-1:0] RATE_RESET = 20'd6000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WAIT,
        ST_PUSH,
        ST_SPAN_RD,
        ST_SPAN,
        ST_RATE_GO,
        ST_RATE,
        ST_FIN
    } t_state;

endpackage

FILE: hdl/swfp_if.sv
// Valid/ready channel interfaces for frame ticks and pacing results.
interface swfp_in_if;
    logic                         valid;
    logic                         ready;
    logic [swfp_pkg::STAMP_W-1:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

interface swfp_out_if;
    logic                        valid;
    logic                        ready;
    logic [swfp_pkg::WAIT_W-1:0] wait_ms;
    logic [swfp_pkg::RATE_W-1:0] rate_centi;
    logic                        rate_updated;

    modport source (output valid, output wait_ms, output rate_centi, output rate_updated,
                     input ready);
    modport sink   (input valid, input wait_ms, input rate_centi, input rate_updated,
                     output ready);
endinterface

FILE: hdl/swfp_ram.sv
// Generic one-write one-read RAM with registered read data.
module swfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 120
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/swfp_div.sv
// Serial restoring divider, one quotient bit per cycle.
module swfp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swfp_pkg::DIV_W-1:0]    i_dividend,
    input  logic [swfp_pkg::DIV_W-1:0]    i_divisor,
    input  logic [swfp_pkg::STEP_W-1:0]   i_steps,
    output logic                          o_done,
    output logic [swfp_pkg::DIV_W-1:0]    o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [swfp_pkg::STEP_W-1:0]   r_cnt;
    logic [swfp_pkg::DIV_W-1:0]    r_rem;
    logic [swfp_pkg::DIV_W-1:0]    r_quo;
    logic [swfp_pkg::DIV_W-1:0]    r_div;

    logic [swfp_pkg::DIV_W:0]      rem_sh;
    logic [swfp_pkg::DIV_W:0]      rem_sub;
    logic                          ge;
    logic [swfp_pkg::DIV_W-1:0]    n_rem;
    logic [swfp_pkg::DIV_W-1:0]    n_quo;

    always_comb begin
        rem_sh  = {r_rem, r_quo[swfp_pkg::DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        ge      = (rem_sh >= {1'b0, r_div});
        n_rem   = ge ? rem_sub[swfp_pkg::DIV_W-1:0] : rem_sh[swfp_pkg::DIV_W-1:0];
        n_quo   = {r_quo[swfp_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == swfp_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider flags done while still busy");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == swfp_pkg::STEP_W'(1) && !i_start) |=> r_done)
        else $error("divider missed done after last step");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with zero step count");

endmodule

FILE: hdl/sliding_window_frame_pacer_top.sv
// Sliding-window frame pacer: stamp ring, reciprocal due multiply and serial divider.
// An accepted tick passes the wait and push states to the final state, which registers the
// result; an update tick on a full ring also passes the span read, span and rate-go states,
// and on nonzero span waits in the rate state for the 33-step serial divide. Ready rises as
// the result is registered, and a result not yet taken holds the sequencer in its final state.
// Reset (synchronous, active low) empties the ring and sets the measured rate to 60.00 fps.
module sliding_window_frame_pacer_top #(
    parameter int WINDOW          = 120,
    parameter int TARGET_FPS      = 60,
    parameter int UPDATE_INTERVAL = 60
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    swfp_in_if.sink           i_frame,
    swfp_out_if.source        o_pace
);

    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int TW = $clog2(UPDATE_INTERVAL + 1);
    localparam int SW = swfp_pkg::STAMP_W;
    localparam int DW = swfp_pkg::DIV_W;
    localparam int UW = swfp_pkg::DUE_W;
    localparam int PW = 48;
    localparam int RECIP_SHIFT = UW + 8;
    localparam logic [CW-1:0] WIN_C  = CW'(WINDOW);
    localparam logic [AW-1:0] HEAD_LAST = AW'(WINDOW - 1);
    localparam logic [TW-1:0] UI_C   = TW'(UPDATE_INTERVAL);
    localparam logic [DW-1:0] RATE_BASE = DW'(swfp_pkg::RATE_SCALE * (WINDOW - 1));
    localparam longint unsigned DUE_RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(TARGET_FPS) - 64'd1) / 64'(TARGET_FPS);
    localparam logic [PW-1:0] DUE_K = PW'(DUE_RECIP * 64'(swfp_pkg::FPS_SCALE));

    swfp_pkg::t_state r_state, n_state;

    logic [SW-1:0]                 r_now, n_now;
    logic [UW-1:0]                 r_due, n_due;
    logic [swfp_pkg::WAIT_W-1:0]   r_wait, n_wait;
    logic [SW-1:0]                 r_newest, n_newest;
    logic [SW-1:0]                 r_span, n_span;
    logic                          r_upd, n_upd;
    logic [AW-1:0]                 r_head, n_head;
    logic [CW-1:0]                 r_count, n_count;
    logic [TW-1:0]                 r_tick, n_tick;
    logic [swfp_pkg::RATE_W-1:0]   r_rate, n_rate;
    logic                          r_out_valid, n_out_valid;
    logic [swfp_pkg::WAIT_W-1:0]   r_out_wait, n_out_wait;
    logic [swfp_pkg::RATE_W-1:0]   r_out_rate, n_out_rate;
    logic                          r_out_upd, n_out_upd;

    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [SW-1:0]        ram_wr_data;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [SW-1:0]        ram_rd_data;

    logic                          div_start;
    logic [DW-1:0]                 div_dividend;
    logic [DW-1:0]                 div_divisor;
    logic [swfp_pkg::STEP_W-1:0]   div_steps;
    logic                          div_done;
    logic [DW-1:0]                 div_quot;

    logic [PW-1:0]        due_prod;
    logic [SW-1:0]        elapsed;
    logic [UW-1:0]        wait_diff;
    logic [SW-1:0]        stamp;
    logic [CW:0]          tail_sum;
    logic [CW:0]          tail_wrap;
    logic [AW-1:0]        tail_addr;
    logic [AW-1:0]        head_inc;
    logic [TW-1:0]        tick_inc;

    swfp_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    swfp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign i_frame.ready       = (r_state == swfp_pkg::ST_IDLE);
    assign o_pace.valid        = r_out_valid;
    assign o_pace.wait_ms      = r_out_wait;
    assign o_pace.rate_centi   = r_out_rate;
    assign o_pace.rate_updated = r_out_upd;

    always_comb begin
        due_prod  = PW'(r_count) * DUE_K;
        elapsed   = r_now - ram_rd_data;
        wait_diff = r_due - elapsed[UW-1:0];
        stamp     = r_now + SW'(r_wait);
        tail_sum  = (CW+1)'(r_head) + (CW+1)'(r_count);
        tail_wrap = (tail_sum >= (CW+1)'(WINDOW)) ? tail_sum - (CW+1)'(WINDOW) : tail_sum;
        tail_addr = tail_wrap[AW-1:0];
        head_inc  = (r_head == HEAD_LAST) ? '0 : r_head + 1'b1;
        tick_inc  = r_tick + 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_due       = r_due;
        n_wait      = r_wait;
        n_newest    = r_newest;
        n_span      = r_span;
        n_upd       = r_upd;
        n_head      = r_head;
        n_count     = r_count;
        n_tick      = r_tick;
        n_rate      = r_rate;
        n_out_valid = r_out_valid && !o_pace.ready;
        n_out_wait  = r_out_wait;
        n_out_rate  = r_out_rate;
        n_out_upd   = r_out_upd;

        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_head;
        ram_wr_data  = stamp;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_head;

        div_start    = 1'b0;
        div_dividend = RATE_BASE + {1'b0, r_span};
        div_divisor  = {r_span, 1'b0};
        div_steps    = swfp_pkg::STEP_W'(DW);

        case (r_state)
            swfp_pkg::ST_IDLE: begin
                if (i_frame.valid) begin
                    n_now     = i_frame.now_ms;
                    n_due     = due_prod[RECIP_SHIFT +: UW];
                    ram_rd_en = 1'b1;
                    n_state   = swfp_pkg::ST_WAIT;
                end
            end
            swfp_pkg::ST_WAIT: begin
                if (r_count != '0 && SW'(r_due) > elapsed) begin
                    if (wait_diff > UW'(swfp_pkg::WAIT_MAX)) begin
                        n_wait = swfp_pkg::WAIT_MAX;
                    end else begin
                        n_wait = wait_diff[swfp_pkg::WAIT_W-1:0];
                    end
                end else begin
                    n_wait = '0;
                end
                n_state = swfp_pkg::ST_PUSH;
            end
            swfp_pkg::ST_PUSH: begin
                ram_wr_en = 1'b1;
                n_newest  = stamp;
                n_upd     = 1'b0;
                if (r_count == WIN_C) begin
                    ram_wr_addr = r_head;
                    n_head      = head_inc;
                end else begin
                    ram_wr_addr = tail_addr;
                    n_count     = r_count + 1'b1;
                end
                if (tick_inc >= UI_C) begin
                    n_tick = '0;
                    if (n_count == WIN_C) begin
                        n_state = swfp_pkg::ST_SPAN_RD;
                    end else begin
                        n_state = swfp_pkg::ST_FIN;
                    end
                end else begin
                    n_tick  = tick_inc;
                    n_state = swfp_pkg::ST_FIN;
                end
            end
            swfp_pkg::ST_SPAN_RD: begin
                ram_rd_en = 1'b1;
                n_state   = swfp_pkg::ST_SPAN;
            end
            swfp_pkg::ST_SPAN: begin
                n_span  = r_newest - ram_rd_data;
                n_state = swfp_pkg::ST_RATE_GO;
            end
            swfp_pkg::ST_RATE_GO: begin
                if (r_span == '0) begin
                    n_state = swfp_pkg::ST_FIN;
                end else begin
                    div_start = 1'b1;
                    n_state   = swfp_pkg::ST_RATE;
                end
            end
            swfp_pkg::ST_RATE: begin
                if (div_done) begin
                    if (div_quot > DW'(swfp_pkg::RATE_MAX)) begin
                        n_rate = swfp_pkg::RATE_MAX;
                    end else begin
                        n_rate = div_quot[swfp_pkg::RATE_W-1:0];
                    end
                    n_upd   = 1'b1;
                    n_state = swfp_pkg::ST_FIN;
                end
            end
            swfp_pkg::ST_FIN: begin
                if (!r_out_valid || o_pace.ready) begin
                    n_out_valid = 1'b1;
                    n_out_wait  = r_wait;
                    n_out_rate  = r_rate;
                    n_out_upd   = r_upd;
                    n_state     = swfp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swfp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swfp_pkg::ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_tick      <= '0;
            r_rate      <= swfp_pkg::RATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_tick      <= n_tick;
            r_rate      <= n_rate;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_due      <= n_due;
        r_wait     <= n_wait;
        r_newest   <= n_newest;
        r_span     <= n_span;
        r_upd      <= n_upd;
        r_out_wait <= n_out_wait;
        r_out_rate <= n_out_rate;
        r_out_upd  <= n_out_upd;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= WIN_C)
        else $error("ring count exceeds window");

    a_head_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != WIN_C) |-> (r_head == '0))
        else $error("ring head moved before ring filled");

    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < UI_C)
        else $error("tick count reached update interval");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == swfp_pkg::ST_RATE))
        else $error("divider finished outside the rate state");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sliding-window frame pacer: random ticks against a predictor.
module testbench;

    localparam int WINDOW          = 120;
    localparam int TARGET_FPS      = 60;
    localparam int UPDATE_INTERVAL = 60;
    localparam int ITEMS           = 740;
    localparam int DRAIN_CYCLES    = 70;

    localparam logic [swfp_pkg::STAMP_W-1:0] OPENING [20] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0010,
        32'h0000_0021, 32'h0000_07D0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
        32'h5555_5555, 32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h0000_0004, 32'h0000_0014,
        32'h0000_0014, 32'h0000_0010, 32'h0001_0000, 32'hFFFE_FFFF, 32'h0001_0000
    };

    typedef struct packed {
        logic [swfp_pkg::WAIT_W-1:0] wait_ms;
        logic [swfp_pkg::RATE_W-1:0] rate_centi;
        logic                        rate_updated;
    } t_pace;

    class t_pacing_tracker;
        logic [swfp_pkg::STAMP_W-1:0] stamps [WINDOW];
        logic [swfp_pkg::STAMP_W-1:0] newest;
        logic [swfp_pkg::RATE_W-1:0]  rate;
        int unsigned                  head;
        int unsigned                  fill;
        int unsigned                  ticks;
        int unsigned                  failures;
        t_pace                        owed_paces [$];

        function new();
            foreach (stamps[i]) stamps[i] = '0;
            newest   = '0;
            rate     = swfp_pkg::RATE_RESET;
            head     = 0;
            fill     = 0;
            ticks    = 0;
            failures = 0;
        endfunction

        function void note_tick(logic [swfp_pkg::STAMP_W-1:0] now);
            t_pace                        p;
            logic [swfp_pkg::STAMP_W-1:0] elapsed;
            logic [swfp_pkg::STAMP_W-1:0] span;
            longint unsigned              due;
            longint unsigned              q;
            ticks++;
            p.wait_ms      = '0;
            p.rate_updated = 1'b0;
            if (fill != 0) begin
                due     = fill * swfp_pkg::FPS_SCALE / TARGET_FPS;
                elapsed = now - stamps[head];
                if (due > elapsed) begin
                    due -= elapsed;
                    p.wait_ms = (due > longint'(swfp_pkg::WAIT_MAX)) ?
                                swfp_pkg::WAIT_MAX : swfp_pkg::WAIT_W'(due);
                end
            end
            newest = now + p.wait_ms;
            if (fill < WINDOW) begin
                stamps[(head + fill) % WINDOW] = newest;
                fill++;
            end else begin
                stamps[head] = newest;
                head = (head + 1) % WINDOW;
            end
            if (ticks >= UPDATE_INTERVAL) begin
                ticks = 0;
                if (fill == WINDOW) begin
                    span = stamps[(head + WINDOW - 1) % WINDOW] - stamps[head];
                    if (span != 0) begin
                        q = (longint'(swfp_pkg::RATE_SCALE) * (WINDOW - 1) + span) /
                            (2 * longint'(span));
                        rate = (q > longint'(swfp_pkg::RATE_MAX)) ?
                               swfp_pkg::RATE_MAX : swfp_pkg::RATE_W'(q);
                        p.rate_updated = 1'b1;
                    end
                end
            end
            p.rate_centi = rate;
            owed_paces.insert(owed_paces.size(), p);
        endfunction

        function void check_pace(logic [swfp_pkg::WAIT_W-1:0] w,
                                 logic [swfp_pkg::RATE_W-1:0] r, logic u);
            t_pace want;
            if (owed_paces.size() == 0) begin
                $error("unexpected pace beat: wait_ms %0d rate_centi %0d rate_updated %0d",
                       w, r, u);
                failures++;
                return;
            end
            want = owed_paces[0];
            owed_paces.delete(0);
            if (w !== want.wait_ms) begin
                $error("wait_ms: expected %0d, actual %0d", want.wait_ms, w);
                failures++;
            end
            if (r !== want.rate_centi) begin
                $error("rate_centi: expected %0d, actual %0d", want.rate_centi, r);
                failures++;
            end
            if (u !== want.rate_updated) begin
                $error("rate_updated: expected %0d, actual %0d", want.rate_updated, u);
                failures++;
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    bit              calm = 1'b0;
    int unsigned     sent = 0;
    t_pacing_tracker board = new();

    swfp_in_if  frame ();
    swfp_out_if pace ();

    sliding_window_frame_pacer_top #(
        .WINDOW          (WINDOW),
        .TARGET_FPS      (TARGET_FPS),
        .UPDATE_INTERVAL (UPDATE_INTERVAL)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame),
        .o_pace  (pace)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int unsigned stall_left;
        stall_left = 0;
        pace.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pace.valid && pace.ready)
                board.check_pace(pace.wait_ms, pace.rate_centi, pace.rate_updated);
            if (stall_left != 0) begin
                stall_left--;
                pace.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 8);
                pace.ready <= 1'b0;
            end else begin
                pace.ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input logic [swfp_pkg::STAMP_W-1:0] now);
        if (!calm && $urandom_range(0, 4) == 0) begin
            frame.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        frame.valid  <= 1'b1;
        frame.now_ms <= now;
        do @(posedge i_clk); while (!frame.ready);
        board.note_tick(now);
        sent++;
        calm = (sent >= ITEMS - 100);
    endtask

    task automatic hold_for_results();
        frame.valid <= 1'b0;
        do @(posedge i_clk); while (board.owed_paces.size() != 0);
    endtask

    task automatic run_episode();
        int unsigned                  pick;
        int unsigned                  n;
        int unsigned                  step;
        logic [swfp_pkg::STAMP_W-1:0] t;
        pick = $urandom_range(0, 99);
        n    = $urandom_range(1, 60);
        if (pick < 45) begin
            repeat (n + 20) send_tick(board.newest + $urandom_range(0, 24));
        end else if (pick < 62) begin
            t    = board.newest;
            step = $urandom_range(0, 40);
            repeat (n) begin
                t += $urandom_range(0, step);
                send_tick(t);
            end
        end else if (pick < 80) begin
            // align so the ring is all post-jump stamps exactly at an update point
            while (board.ticks != 0) send_tick(board.newest + $urandom_range(0, 24));
            t    = $urandom;
            step = $urandom_range(0, 2);
            repeat (WINDOW) begin
                send_tick(t);
                case (step)
                    0: t = t;
                    1: t += ($urandom_range(0, 15) == 0);
                    default: t += $urandom_range(0, 3);
                endcase
            end
        end else if (pick < 92) begin
            repeat (n % 10 + 1) send_tick($urandom);
        end else begin
            t = board.newest;
            repeat (n % 10 + 1) begin
                t -= $urandom_range(1, 5000);
                send_tick(t);
            end
        end
        if ($urandom_range(0, 5) == 0)
            hold_for_results();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        frame.valid  <= 1'b0;
        frame.now_ms <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (OPENING[i]) send_tick(OPENING[i]);
        hold_for_results();
        while (sent < ITEMS) run_episode();
        hold_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.failures == 0 && board.owed_paces.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/swfp_pkg.sv
hdl/swfp_if.sv
hdl/swfp_ram.sv
hdl/swfp_div.sv
hdl/sliding_window_frame_pacer_top.sv
test/testbench.sv
